// ===== src/msp_pkg.sv =====
// Shared widths, defaults and walker status type for the max-sum path block.
package msp_pkg;

  // Fixed field widths of the input and result words
  localparam int unsigned BALLS_W   = 20;
  localparam int unsigned TOTAL_W   = 31;

  // Default store geometry
  localparam int unsigned DEPTH_DEF      = 1024;
  localparam int unsigned VALUE_BITS_DEF = 20;

  // Saturation ceiling of the reported total
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  // Walker status seen by the load and output control
  typedef struct packed {
    logic busy;
    logic done;
  } walk_sts_t;

endpackage

// ===== src/msp_if.sv =====
// Valid/ready channel interfaces for input words and result words.
interface msp_in_if
  import msp_pkg::*;
  ();
  logic               valid;
  logic               ready;
  logic               which_road;
  logic [BALLS_W-1:0] balls;
  logic               last_of_set;

  modport source (output valid, output which_road, output balls, output last_of_set,
                  input ready);
  modport sink   (input valid, input which_road, input balls, input last_of_set,
                  output ready);
endinterface

interface msp_out_if
  import msp_pkg::*;
  ();
  logic               valid;
  logic               ready;
  logic [TOTAL_W-1:0] max_total;
  logic               overflowed;

  modport source (output valid, output max_total, output overflowed, input ready);
  modport sink   (input valid, input max_total, input overflowed, output ready);
endinterface

// ===== src/msp_road_mem.sv =====
// Single-port-write, registered-read store for one road's values.
module msp_road_mem #(
  parameter int unsigned DEPTH = msp_pkg::DEPTH_DEF,
  parameter int unsigned WIDTH = msp_pkg::VALUE_BITS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  wr_en_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]                      wr_data_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]                      rd_data_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  // Write on request, registered read every cycle
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    rd_data_q <= mem[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== src/msp_walker.sv =====
// Merge walk over both road stores, keeping segment sums and the path total.
module msp_walker
  import msp_pkg::*;
#(
  parameter int unsigned DEPTH      = DEPTH_DEF,
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF,
  localparam int unsigned STORE_BITS = (VALUE_BITS < BALLS_W) ? VALUE_BITS : BALLS_W,
  localparam int unsigned CNT_BITS   = $clog2(DEPTH + 1),
  localparam int unsigned ADDR_BITS  = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic                  take_i,
  input  logic [CNT_BITS-1:0]   cnt_a_i,
  input  logic [CNT_BITS-1:0]   cnt_b_i,
  input  logic [STORE_BITS-1:0] rd_a_i,
  input  logic [STORE_BITS-1:0] rd_b_i,
  output logic [ADDR_BITS-1:0]  addr_a_o,
  output logic [ADDR_BITS-1:0]  addr_b_o,
  output walk_sts_t             sts_o,
  output logic [TOTAL_W-1:0]    total_o
);

  localparam int unsigned SUM_BITS = STORE_BITS + $clog2(2 * DEPTH) + 1;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_PRIME  = 3'd1;
  localparam logic [2:0] ST_WALK   = 3'd2;
  localparam logic [2:0] ST_MERGE  = 3'd3;
  localparam logic [2:0] ST_FINISH = 3'd4;

  logic [2:0]          state_q, state_d;
  logic [CNT_BITS-1:0] a_q, a_d, b_q, b_d;
  logic [SUM_BITS-1:0] seg1_q, seg1_d, seg2_q, seg2_d, total_q, total_d;
  logic                a_live, b_live;
  logic [SUM_BITS-1:0] x_ext, y_ext, seg_max;

  assign a_live  = a_q < cnt_a_i;
  assign b_live  = b_q < cnt_b_i;
  assign x_ext   = SUM_BITS'(rd_a_i);
  assign y_ext   = SUM_BITS'(rd_b_i);
  assign seg_max = (seg1_q > seg2_q) ? seg1_q : seg2_q;

  // Advance the lower or only live head; a tie advances both, then merges
  always_comb begin
    state_d = state_q;
    a_d     = a_q;
    b_d     = b_q;
    seg1_d  = seg1_q;
    seg2_d  = seg2_q;
    total_d = total_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          state_d = ST_PRIME;
          a_d     = '0;
          b_d     = '0;
          seg1_d  = '0;
          seg2_d  = '0;
          total_d = '0;
        end
      end
      ST_PRIME: begin
        state_d = ST_WALK;
      end
      ST_WALK: begin
        priority if (a_live && b_live) begin
          priority if (rd_a_i < rd_b_i) begin
            seg1_d = seg1_q + x_ext;
            a_d    = a_q + CNT_BITS'(1);
          end else if (rd_a_i > rd_b_i) begin
            seg2_d = seg2_q + y_ext;
            b_d    = b_q + CNT_BITS'(1);
          end else begin
            seg1_d  = seg1_q + x_ext;
            seg2_d  = seg2_q + y_ext;
            a_d     = a_q + CNT_BITS'(1);
            b_d     = b_q + CNT_BITS'(1);
            state_d = ST_MERGE;
          end
        end else if (a_live) begin
          seg1_d = seg1_q + x_ext;
          a_d    = a_q + CNT_BITS'(1);
        end else if (b_live) begin
          seg2_d = seg2_q + y_ext;
          b_d    = b_q + CNT_BITS'(1);
        end else begin
          state_d = ST_MERGE;
        end
      end
      ST_MERGE: begin
        total_d = total_q + seg_max;
        seg1_d  = '0;
        seg2_d  = '0;
        state_d = (!a_live && !b_live) ? ST_FINISH : ST_WALK;
      end
      ST_FINISH: begin
        if (take_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Hold control state; sums are cleared on start
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      a_q     <= '0;
      b_q     <= '0;
    end else begin
      state_q <= state_d;
      a_q     <= a_d;
      b_q     <= b_d;
    end
  end

  always_ff @(posedge clk_i) begin
    seg1_q  <= seg1_d;
    seg2_q  <= seg2_d;
    total_q <= total_d;
  end

  // Read ahead at the next index so the heads are ready each walk cycle
  assign addr_a_o   = a_d[ADDR_BITS-1:0];
  assign addr_b_o   = b_d[ADDR_BITS-1:0];
  assign sts_o.busy = state_q != ST_IDLE;
  assign sts_o.done = state_q == ST_FINISH;

  // Saturate the total to the result width
  generate
    if (SUM_BITS > TOTAL_W) begin : g_sat
      assign total_o = (total_q > SUM_BITS'(TOTAL_MAX)) ? TOTAL_MAX
                                                         : total_q[TOTAL_W-1:0];
    end else begin : g_nosat
      assign total_o = TOTAL_W'(total_q);
    end
  endgenerate

endmodule

// ===== src/max_sum_path_two_sorted.sv =====
// Walk: after the last word of a set, the walker merges the na and nb stored words, one walk
// step per unequal head, a walk step and a merge step per equal pair, then the result.
// Throughput: one input word per cycle while loading; input is held off during the walk,
// and while a finished result waits for the output register to take it.
// Reset: counts, drop flag, walker state and result valid clear at once; stores are
// not cleared, and their words are used only below the counts.
module max_sum_path_two_sorted
  import msp_pkg::*;
#(
  parameter int unsigned DEPTH      = DEPTH_DEF,
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  msp_in_if.sink    in_i,
  msp_out_if.source out_o
);

  localparam int unsigned STORE_BITS = (VALUE_BITS < BALLS_W) ? VALUE_BITS : BALLS_W;
  localparam int unsigned CNT_BITS   = $clog2(DEPTH + 1);
  localparam int unsigned ADDR_BITS  = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [CNT_BITS-1:0]   cnt_a_q, cnt_b_q;
  logic                  drop_q;
  logic                  out_valid_q;
  logic [TOTAL_W-1:0]    out_total_q;
  logic                  out_flag_q;
  walk_sts_t             sts;
  logic                  accept, full_a, full_b, wr_a, wr_b, dropped, take;
  logic [STORE_BITS-1:0] wr_data, rd_a, rd_b;
  logic [ADDR_BITS-1:0]  addr_a, addr_b;
  logic [TOTAL_W-1:0]    total;

  // Accept words only while the walker is idle
  assign in_i.ready = !sts.busy;
  assign accept     = in_i.valid && in_i.ready;
  assign full_a     = cnt_a_q == CNT_BITS'(DEPTH);
  assign full_b     = cnt_b_q == CNT_BITS'(DEPTH);
  assign wr_a       = accept && !in_i.which_road && !full_a;
  assign wr_b       = accept && in_i.which_road && !full_b;
  assign dropped    = accept && (in_i.which_road ? full_b : full_a);
  assign wr_data    = in_i.balls[STORE_BITS-1:0];

  // Hand the result over when the output register is free or draining
  assign take = sts.done && (!out_valid_q || out_o.ready);

  // Advance counts and drop flag; clear them when the result is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_a_q     <= '0;
      cnt_b_q     <= '0;
      drop_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (take) begin
        cnt_a_q     <= '0;
        cnt_b_q     <= '0;
        drop_q      <= 1'b0;
        out_valid_q <= 1'b1;
      end else begin
        if (wr_a) begin
          cnt_a_q <= cnt_a_q + CNT_BITS'(1);
        end
        if (wr_b) begin
          cnt_b_q <= cnt_b_q + CNT_BITS'(1);
        end
        if (dropped) begin
          drop_q <= 1'b1;
        end
        if (out_valid_q && out_o.ready) begin
          out_valid_q <= 1'b0;
        end
      end
    end
  end

  // Load the result word
  always_ff @(posedge clk_i) begin
    if (take) begin
      out_total_q <= total;
      out_flag_q  <= drop_q;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.max_total  = out_total_q;
  assign out_o.overflowed = out_flag_q;

  msp_road_mem #(
    .DEPTH (DEPTH),
    .WIDTH (STORE_BITS)
  ) u_mem_a (
    .clk_i     (clk_i),
    .wr_en_i   (wr_a),
    .wr_addr_i (cnt_a_q[ADDR_BITS-1:0]),
    .wr_data_i (wr_data),
    .rd_addr_i (addr_a),
    .rd_data_o (rd_a)
  );

  msp_road_mem #(
    .DEPTH (DEPTH),
    .WIDTH (STORE_BITS)
  ) u_mem_b (
    .clk_i     (clk_i),
    .wr_en_i   (wr_b),
    .wr_addr_i (cnt_b_q[ADDR_BITS-1:0]),
    .wr_data_i (wr_data),
    .rd_addr_i (addr_b),
    .rd_data_o (rd_b)
  );

  msp_walker #(
    .DEPTH      (DEPTH),
    .VALUE_BITS (VALUE_BITS)
  ) u_walker (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (accept && in_i.last_of_set),
    .take_i   (take),
    .cnt_a_i  (cnt_a_q),
    .cnt_b_i  (cnt_b_q),
    .rd_a_i   (rd_a),
    .rd_b_i   (rd_b),
    .addr_a_o (addr_a),
    .addr_b_o (addr_b),
    .sts_o    (sts),
    .total_o  (total)
  );

endmodule

// ===== verif/tb_max_sum_path_two_sorted.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the max-sum path block over two sorted sequences.
module tb_max_sum_path_two_sorted;
  import msp_pkg::*;

  localparam int unsigned STORE_DEPTH    = DEPTH_DEF;
  localparam int unsigned WATCHDOG_LIMIT = 20000;
  localparam int unsigned LONG_HOLD      = 300;
  localparam int unsigned DRAIN_CYCLES   = 2 * STORE_DEPTH + 16;
  localparam int unsigned MAX_REPORTS    = 10;
  localparam int unsigned BALLS_TOP      = (1 << BALLS_W) - 1;
  localparam logic        FIRST_ROAD     = 1'b0;
  localparam logic        SECOND_ROAD    = 1'b1;

  typedef enum int {SET_SORTED, SET_NOISE, SET_ONE_ROAD, SET_LONG} set_kind_e;

  typedef struct packed {
    logic [TOTAL_W-1:0] total;
    logic               ovf;
  } path_result_t;

  typedef logic [BALLS_W-1:0] ball_q_t[$];

  // Directed word: typed marks rows whose result is written out by hand
  typedef struct packed {
    logic               road;
    logic [BALLS_W-1:0] val;
    logic               last;
    logic               typed;
    logic [TOTAL_W-1:0] tot;
    logic               ovf;
  } probe_row_t;

  localparam int unsigned PROBE_N = 24;
  localparam probe_row_t PROBE_ROWS [PROBE_N] = '{
    // single zero on the first road
    '{FIRST_ROAD,  20'h00000, 1'b1, 1'b1, 31'd0,       1'b0},
    // second road only, top value
    '{SECOND_ROAD, 20'hFFFFF, 1'b1, 1'b1, 31'h000FFFFF, 1'b0},
    // top values meeting once, tail on the first road
    '{FIRST_ROAD,  20'hFFFFF, 1'b0, 1'b0, 31'd0,       1'b0},
    '{FIRST_ROAD,  20'hFFFFF, 1'b0, 1'b0, 31'd0,       1'b0},
    '{SECOND_ROAD, 20'hFFFFF, 1'b1, 1'b1, 31'h001FFFFE, 1'b0},
    // one crossing at equal heads
    '{FIRST_ROAD,  20'd1,     1'b0, 1'b0, 31'd0,       1'b0},
    '{SECOND_ROAD, 20'd3,     1'b0, 1'b0, 31'd0,       1'b0},
    '{FIRST_ROAD,  20'd5,     1'b0, 1'b0, 31'd0,       1'b0},
    '{SECOND_ROAD, 20'd5,     1'b1, 1'b1, 31'd8,       1'b0},
    // two crossings, last word on the second road
    '{SECOND_ROAD, 20'd2,     1'b0, 1'b0, 31'd0,       1'b0},
    '{FIRST_ROAD,  20'd2,     1'b0, 1'b0, 31'd0,       1'b0},
    '{FIRST_ROAD,  20'd7,     1'b0, 1'b0, 31'd0,       1'b0},
    '{SECOND_ROAD, 20'd4,     1'b0, 1'b0, 31'd0,       1'b0},
    '{SECOND_ROAD, 20'd7,     1'b0, 1'b0, 31'd0,       1'b0},
    '{SECOND_ROAD, 20'd9,     1'b1, 1'b0, 31'd0,       1'b0},
    // unsorted first road
    '{FIRST_ROAD,  20'd9,     1'b0, 1'b0, 31'd0,       1'b0},
    '{FIRST_ROAD,  20'd2,     1'b0, 1'b0, 31'd0,       1'b0},
    '{SECOND_ROAD, 20'd4,     1'b1, 1'b0, 31'd0,       1'b0},
    // all zeros, every pair equal
    '{FIRST_ROAD,  20'd0,     1'b0, 1'b0, 31'd0,       1'b0},
    '{SECOND_ROAD, 20'd0,     1'b0, 1'b0, 31'd0,       1'b0},
    '{FIRST_ROAD,  20'd0,     1'b0, 1'b0, 31'd0,       1'b0},
    '{SECOND_ROAD, 20'd0,     1'b1, 1'b1, 31'd0,       1'b0},
    // alternating bit patterns, no crossing
    '{SECOND_ROAD, 20'h55555, 1'b0, 1'b0, 31'd0,       1'b0},
    '{FIRST_ROAD,  20'hAAAAA, 1'b1, 1'b0, 31'd0,       1'b0}
  };

  logic clk_i;
  logic rst_ni;

  msp_in_if  in_ch ();
  msp_out_if out_ch ();

  max_sum_path_two_sorted dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  // Path model state
  logic [BALLS_W-1:0] first_img  [STORE_DEPTH];
  logic [BALLS_W-1:0] second_img [STORE_DEPTH];
  int unsigned        first_len;
  int unsigned        second_len;
  bit                 drop_seen;

  path_result_t totals_due[$];
  int unsigned  mismatch_count;
  int unsigned  words_sent;
  int unsigned  stall_run;
  bit           src_idle_on;
  bit           sink_idle_on;
  bit           hold_req;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Merge-walk both images, switching roads only at equal heads
  function automatic longint unsigned walk_best_path();
    int unsigned       a = 0;
    int unsigned       b = 0;
    longint unsigned   seg_a = 0;
    longint unsigned   seg_b = 0;
    longint unsigned   total = 0;
    while (a < first_len && b < second_len) begin
      if (first_img[a] < second_img[b]) begin
        seg_a += 64'(first_img[a]);
        a++;
      end else if (first_img[a] > second_img[b]) begin
        seg_b += 64'(second_img[b]);
        b++;
      end else begin
        seg_a += 64'(first_img[a]);
        seg_b += 64'(second_img[b]);
        a++;
        b++;
        total += (seg_a > seg_b) ? seg_a : seg_b;
        seg_a = 0;
        seg_b = 0;
      end
    end
    while (a < first_len) begin
      seg_a += 64'(first_img[a]);
      a++;
    end
    while (b < second_len) begin
      seg_b += 64'(second_img[b]);
      b++;
    end
    total += (seg_a > seg_b) ? seg_a : seg_b;
    return total;
  endfunction

  // Store one accepted word; on the set's last word produce the result
  function automatic void absorb_word(input logic road, input logic [BALLS_W-1:0] val,
                                      input logic last, output bit emits,
                                      output path_result_t res);
    longint unsigned total;
    emits = 1'b0;
    res   = '0;
    if (road == FIRST_ROAD) begin
      if (first_len < STORE_DEPTH) begin
        first_img[first_len] = val;
        first_len++;
      end else begin
        drop_seen = 1'b1;
      end
    end else begin
      if (second_len < STORE_DEPTH) begin
        second_img[second_len] = val;
        second_len++;
      end else begin
        drop_seen = 1'b1;
      end
    end
    if (last) begin
      total = walk_best_path();
      if (total > 64'(TOTAL_MAX)) total = 64'(TOTAL_MAX);
      res.total  = total[TOTAL_W-1:0];
      res.ovf    = drop_seen;
      emits      = 1'b1;
      first_len  = 0;
      second_len = 0;
      drop_seen  = 1'b0;
    end
  endfunction

  function automatic void flag_mismatch(string what);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) $display("%0t mismatch: %s", $time, what);
  endfunction

  // Nondecreasing run from base, clamped at the top value
  function automatic void rising_run(input int unsigned n, input int unsigned base,
                                     output ball_q_t vals);
    int unsigned v = base;
    vals = {};
    for (int unsigned i = 0; i < n; i++) begin
      v += $urandom_range(0, 3);
      if (v > BALLS_TOP) v = BALLS_TOP;
      vals.push_back(v[BALLS_W-1:0]);
    end
  endfunction

  // Offer one word, wait for it to be taken, then update the model
  task automatic push_word(input logic road, input logic [BALLS_W-1:0] val, input logic last,
                           input bit typed, input logic [TOTAL_W-1:0] typed_tot,
                           input logic typed_ovf);
    bit           emits;
    path_result_t res;
    int unsigned  gap;
    gap = (src_idle_on && $urandom_range(0, 5) == 0) ? $urandom_range(1, 9) : 0;
    @(negedge clk_i);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_ch.valid       <= 1'b1;
    in_ch.which_road  <= road;
    in_ch.balls       <= val;
    in_ch.last_of_set <= last;
    do @(posedge clk_i); while (!in_ch.ready);
    absorb_word(road, val, last, emits, res);
    if (emits) begin
      if (typed) begin
        res.total = typed_tot;
        res.ovf   = typed_ovf;
      end
      totals_due.push_back(res);
    end
    words_sent++;
  endtask

  task automatic send_plain(input logic road, input logic [BALLS_W-1:0] val, input logic last);
    push_word(road, val, last, 1'b0, '0, 1'b0);
  endtask

  // Drop valid and hold until every due result has come back
  task automatic wait_drained();
    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    while (totals_due.size() != 0) @(posedge clk_i);
  endtask

  // One set: two runs from a shared base interleaved at random, or noise
  task automatic send_set(input set_kind_e kind, input int unsigned na, input int unsigned nb);
    ball_q_t     qa;
    ball_q_t     qb;
    int unsigned base;
    int unsigned ia = 0;
    int unsigned ib = 0;
    logic        road;
    if (na + nb == 0) na = 1;
    if (kind == SET_NOISE) begin
      for (int unsigned i = 0; i < na + nb; i++)
        send_plain(logic'($urandom_range(0, 1)), BALLS_W'($urandom_range(0, BALLS_TOP)),
                   i + 1 == na + nb);
    end else begin
      base = ($urandom_range(0, 3) == 0) ? $urandom_range(BALLS_TOP - 64, BALLS_TOP)
                                         : $urandom_range(0, BALLS_TOP);
      rising_run(na, base, qa);
      rising_run(nb, base, qb);
      while (ia < na || ib < nb) begin
        if (ia == na) road = SECOND_ROAD;
        else if (ib == nb) road = FIRST_ROAD;
        else road = logic'($urandom_range(0, 1));
        if (road == FIRST_ROAD) begin
          send_plain(FIRST_ROAD, qa[ia], ia + ib + 1 == na + nb);
          ia++;
        end else begin
          send_plain(SECOND_ROAD, qb[ib], ia + ib + 1 == na + nb);
          ib++;
        end
      end
    end
  endtask

  task automatic send_random_set();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) send_set(SET_SORTED, $urandom_range(0, 12), $urandom_range(0, 12));
    else if (pick < 85) send_set(SET_NOISE, $urandom_range(1, 12), 0);
    else if (pick < 95) begin
      if ($urandom_range(0, 1) == 0) send_set(SET_ONE_ROAD, $urandom_range(1, 10), 0);
      else send_set(SET_ONE_ROAD, 0, $urandom_range(1, 10));
    end else send_set(SET_LONG, $urandom_range(20, 60), $urandom_range(20, 60));
  endtask

  // Result receiver: random stall bursts, or one long hold on request
  initial begin
    out_ch.ready = 1'b0;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD - 1) @(negedge clk_i);
      end else if (sink_idle_on && $urandom_range(0, 7) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(0, 8)) @(negedge clk_i);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Compare each taken result with the oldest one due
  always @(posedge clk_i) begin : result_check
    path_result_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (totals_due.size() == 0) begin
        flag_mismatch($sformatf("result with none due: max_total %0d overflowed %0b",
                                out_ch.max_total, out_ch.overflowed));
      end else begin
        want = totals_due.pop_front();
        if (out_ch.max_total !== want.total)
          flag_mismatch($sformatf("max_total expected %0d got %0d",
                                  want.total, out_ch.max_total));
        if (out_ch.overflowed !== want.ovf)
          flag_mismatch($sformatf("overflowed expected %0b got %0b",
                                  want.ovf, out_ch.overflowed));
      end
    end
  end

  // Count cycles with work pending and no word moving on either side
  always @(posedge clk_i) begin
    if (!rst_ni || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stall_run = 0;
    end else if (totals_due.size() != 0 || in_ch.valid) begin
      stall_run++;
      if (stall_run >= WATCHDOG_LIMIT) begin
        $display("FAIL max_sum_path_two_sorted");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int unsigned stop_at;
    int unsigned v;
    mismatch_count = 0;
    words_sent     = 0;
    stall_run      = 0;
    first_len      = 0;
    second_len     = 0;
    drop_seen      = 1'b0;
    src_idle_on    = 1'b0;
    sink_idle_on   = 1'b0;
    hold_req       = 1'b0;
    rst_ni            = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.which_road  = FIRST_ROAD;
    in_ch.balls       = '0;
    in_ch.last_of_set = 1'b0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed table
    sink_idle_on = 1'b1;
    for (int unsigned i = 0; i < PROBE_N; i++)
      push_word(PROBE_ROWS[i].road, PROBE_ROWS[i].val, PROBE_ROWS[i].last,
                PROBE_ROWS[i].typed, PROBE_ROWS[i].tot, PROBE_ROWS[i].ovf);
    wait_drained();

    // Hold results back while words keep coming, so the input stalls
    sink_idle_on = 1'b0;
    hold_req     = 1'b1;
    repeat (20) send_set(SET_SORTED, $urandom_range(1, 6), $urandom_range(1, 6));
    wait_drained();

    // Full first store, dropped words, the last one dropped too
    v = $urandom_range(0, 200);
    for (int unsigned i = 0; i < 4; i++) send_plain(SECOND_ROAD, BALLS_W'(v + 150 * i), 1'b0);
    for (int unsigned i = 0; i < STORE_DEPTH + 3; i++)
      send_plain(FIRST_ROAD, BALLS_W'(v + 50 * i), i == STORE_DEPTH + 2);
    wait_drained();

    // Full second store at the top value, matched on the first road
    src_idle_on  = 1'b1;
    sink_idle_on = 1'b1;
    for (int unsigned i = 0; i < 3; i++) send_plain(FIRST_ROAD, BALLS_W'(BALLS_TOP), 1'b0);
    for (int unsigned i = 0; i < STORE_DEPTH + 1; i++)
      send_plain(SECOND_ROAD, BALLS_W'(BALLS_TOP), i == STORE_DEPTH);
    wait_drained();

    // Random sets with idling on both sides
    stop_at = words_sent + 300;
    while (words_sent < stop_at) begin
      send_random_set();
      if ($urandom_range(0, 19) == 0) wait_drained();
    end
    wait_drained();

    // Closing stretch at full rate
    src_idle_on  = 1'b0;
    sink_idle_on = 1'b0;
    stop_at = words_sent + 100;
    while (words_sent < stop_at) send_random_set();
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0 && totals_due.size() == 0) begin
      $display("PASS max_sum_path_two_sorted");
    end else begin
      $display("FAIL max_sum_path_two_sorted");
    end
    $finish;
  end

endmodule
